/* rtl/core/pcmmix_pkg.sv */
// Shared constants, command codes, controller state type and the
// controller/datapath handshake structs of the PCM channel mixer.
// No dependencies.
package pcmmix_pkg;

  // Sizing
  localparam int CHANNELS    = 8;
  localparam int MAX_CHUNK   = 64;
  localparam int STORE_DEPTH = 65536;   // power of two, addresses wrap

  localparam int SAMPLE_W = 16;
  localparam int GAIN_W   = 7;
  localparam int FIELD_W  = 16;         // base, length, position, address
  localparam int MASK_W   = 8;
  localparam int CHAN_W   = 3;          // width of the channel field
  localparam int OP_W     = 3;
  localparam int COUNT_W  = 7;          // width of the sample_count field

  localparam int ADDR_W = $clog2(STORE_DEPTH);
  localparam int CH_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int CNT_W  = $clog2(MAX_CHUNK + 1);
  localparam int PROD_W = SAMPLE_W + GAIN_W + 1;
  localparam int ACC_W  = SAMPLE_W + CH_W + 1;

  localparam logic signed [ACC_W-1:0] MIX_MAX = ACC_W'(32767);
  localparam logic signed [ACC_W-1:0] MIX_MIN = ACC_W'(-32767);

  // Command codes
  localparam logic [OP_W-1:0] CMD_START  = 3'd0;
  localparam logic [OP_W-1:0] CMD_STOP   = 3'd1;
  localparam logic [OP_W-1:0] CMD_VOLUME = 3'd2;
  localparam logic [OP_W-1:0] CMD_WRITE  = 3'd3;
  localparam logic [OP_W-1:0] CMD_FILL   = 3'd4;
  localparam logic [OP_W-1:0] CMD_QUERY  = 3'd5;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_EXEC,
    ST_STATUS,
    ST_PREP,
    ST_RUN,
    ST_DRAIN1,
    ST_DRAIN2,
    ST_OUT,
    ST_FINISH
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic             latch;      // capture the incoming item
    logic             exec;       // apply a non-fill command
    logic             prep;       // snapshot voices, settle end-of-fill flags
    logic             issue;      // read one channel's sample
    logic             finish;     // advance voice positions
    logic             load_out;   // load the result register
    logic             out_fill;   // result carries the mixed sample
    logic             out_last;
    logic [CH_W-1:0]  chan_idx;
    logic [CNT_W-1:0] sample_idx;
  } ctl_t;

  // Datapath to controller
  typedef struct packed {
    logic [OP_W-1:0]  op;
    logic [CNT_W-1:0] cnt;
    logic             out_free;
  } stat_t;

endpackage

/* rtl/core/pcmmix_cmd_if.sv */
// Command channel of the PCM channel mixer: valid/ready plus item fields.
// Depends on pcmmix_pkg.
interface pcmmix_cmd_if;
  logic                                   valid;
  logic                                   ready;
  logic [pcmmix_pkg::OP_W-1:0]            command;
  logic [pcmmix_pkg::CHAN_W-1:0]          channel;
  logic [pcmmix_pkg::GAIN_W-1:0]          volume;
  logic [pcmmix_pkg::FIELD_W-1:0]         address;
  logic [pcmmix_pkg::FIELD_W-1:0]         length;
  logic signed [pcmmix_pkg::SAMPLE_W-1:0] sample_value;
  logic [pcmmix_pkg::COUNT_W-1:0]         sample_count;

  modport source (
    output valid, command, channel, volume, address, length, sample_value, sample_count,
    input  ready
  );
  modport sink (
    input  valid, command, channel, volume, address, length, sample_value, sample_count,
    output ready
  );
endinterface

/* rtl/core/pcmmix_res_if.sv */
// Result channel of the PCM channel mixer: valid/ready plus item fields.
// Depends on pcmmix_pkg.
interface pcmmix_res_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [pcmmix_pkg::SAMPLE_W-1:0] mixed_sample;
  logic                                   last;
  logic                                   channel_active;
  logic                                   any_active;
  logic [pcmmix_pkg::MASK_W-1:0]          active_mask;

  modport source (
    output valid, mixed_sample, last, channel_active, any_active, active_mask,
    input  ready
  );
  modport sink (
    input  valid, mixed_sample, last, channel_active, any_active, active_mask,
    output ready
  );
endinterface

/* rtl/core/pcm_channel_mixer_top.sv */
// Sequence: a non-fill item passes decode, execute and status, where its result item is
// loaded; the next item is taken back in idle. A fill passes decode and setup, then per
// output sample one store read per channel, then the multiply/accumulate drain and the
// output state, then advances positions and returns to idle; result stalls hold the
// status and output states.
// Reset: synchronous, clears all voices to inactive; sample store is not cleared.
module pcm_channel_mixer_top (
  input logic          clk,
  input logic          rst,
  pcmmix_cmd_if.sink   cmd,
  pcmmix_res_if.source res
);

  pcmmix_pkg::ctl_t  ctl;
  pcmmix_pkg::stat_t stat;
  logic              in_ready;

  assign cmd.ready = in_ready;

  // Sequencer
  pcmmix_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (cmd.valid),
    .in_ready (in_ready),
    .stat     (stat),
    .ctl      (ctl)
  );

  // Voices, store and mixing datapath
  pcmmix_dp u_dp (
    .clk             (clk),
    .rst             (rst),
    .ctl             (ctl),
    .stat            (stat),
    .command         (cmd.command),
    .channel         (cmd.channel),
    .volume          (cmd.volume),
    .address         (cmd.address),
    .length          (cmd.length),
    .sample_value    (cmd.sample_value),
    .sample_count    (cmd.sample_count),
    .res_valid       (res.valid),
    .res_ready       (res.ready),
    .res_sample      (res.mixed_sample),
    .res_last        (res.last),
    .res_chan_active (res.channel_active),
    .res_any_active  (res.any_active),
    .res_mask        (res.active_mask)
  );

endmodule

/* rtl/core/pcmmix_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module pcmmix_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

/* rtl/core/pcmmix_ctrl.sv */
// Sequencer of the PCM channel mixer: command decode, channel and sample
// counters, result pacing. Depends on pcmmix_pkg.
module pcmmix_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  pcmmix_pkg::stat_t   stat,
  output pcmmix_pkg::ctl_t    ctl
);

  localparam logic [pcmmix_pkg::CH_W-1:0] CH_LAST =
    pcmmix_pkg::CH_W'(pcmmix_pkg::CHANNELS - 1);

  pcmmix_pkg::state_t state, state_next;
  logic [pcmmix_pkg::CH_W-1:0]  c_idx, c_idx_next;
  logic [pcmmix_pkg::CNT_W-1:0] j_idx, j_idx_next;
  logic                         j_last;

  assign j_last = (j_idx == pcmmix_pkg::CNT_W'(stat.cnt - pcmmix_pkg::CNT_W'(1)));

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      pcmmix_pkg::ST_IDLE:   if (in_valid) state_next = pcmmix_pkg::ST_DECODE;
      pcmmix_pkg::ST_DECODE: begin
        if (stat.op == pcmmix_pkg::CMD_FILL) state_next = pcmmix_pkg::ST_PREP;
        else                                 state_next = pcmmix_pkg::ST_EXEC;
      end
      pcmmix_pkg::ST_EXEC:   state_next = pcmmix_pkg::ST_STATUS;
      pcmmix_pkg::ST_STATUS: if (stat.out_free) state_next = pcmmix_pkg::ST_IDLE;
      pcmmix_pkg::ST_PREP: begin
        if (stat.cnt == '0) state_next = pcmmix_pkg::ST_FINISH;
        else                state_next = pcmmix_pkg::ST_RUN;
      end
      pcmmix_pkg::ST_RUN:    if (c_idx == CH_LAST) state_next = pcmmix_pkg::ST_DRAIN1;
      pcmmix_pkg::ST_DRAIN1: state_next = pcmmix_pkg::ST_DRAIN2;
      pcmmix_pkg::ST_DRAIN2: state_next = pcmmix_pkg::ST_OUT;
      pcmmix_pkg::ST_OUT: begin
        if (stat.out_free) begin
          if (j_last) state_next = pcmmix_pkg::ST_FINISH;
          else        state_next = pcmmix_pkg::ST_RUN;
        end
      end
      pcmmix_pkg::ST_FINISH: state_next = pcmmix_pkg::ST_IDLE;
      default:               state_next = pcmmix_pkg::ST_IDLE;
    endcase
  end

  // Counters: channel steps every RUN cycle, sample steps per delivered item
  always_comb begin
    c_idx_next = c_idx;
    j_idx_next = j_idx;
    if (state == pcmmix_pkg::ST_PREP) begin
      c_idx_next = '0;
      j_idx_next = '0;
    end else if (state == pcmmix_pkg::ST_RUN) begin
      c_idx_next = (c_idx == CH_LAST) ? '0 : pcmmix_pkg::CH_W'(c_idx + 1'b1);
    end else if (state == pcmmix_pkg::ST_OUT && stat.out_free && !j_last) begin
      j_idx_next = pcmmix_pkg::CNT_W'(j_idx + 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pcmmix_pkg::ST_IDLE;
      c_idx <= '0;
      j_idx <= '0;
    end else begin
      state <= state_next;
      c_idx <= c_idx_next;
      j_idx <= j_idx_next;
    end
  end

  // Outputs
  always_comb begin
    in_ready       = (state == pcmmix_pkg::ST_IDLE);
    ctl            = '0;
    ctl.chan_idx   = c_idx;
    ctl.sample_idx = j_idx;
    ctl.latch      = (state == pcmmix_pkg::ST_IDLE) && in_valid;
    ctl.exec       = (state == pcmmix_pkg::ST_EXEC);
    ctl.prep       = (state == pcmmix_pkg::ST_PREP);
    ctl.issue      = (state == pcmmix_pkg::ST_RUN);
    ctl.finish     = (state == pcmmix_pkg::ST_FINISH);
    ctl.load_out   = ((state == pcmmix_pkg::ST_STATUS) || (state == pcmmix_pkg::ST_OUT))
                     && stat.out_free;
    ctl.out_fill   = (state == pcmmix_pkg::ST_OUT);
    ctl.out_last   = (state == pcmmix_pkg::ST_STATUS) || j_last;
  end

endmodule

/* rtl/core/pcmmix_dp.sv */
// Datapath of the PCM channel mixer: item capture, voice registers, sample
// store, multiply/accumulate pipeline and result register.
// Depends on pcmmix_pkg and pcmmix_ram.
module pcmmix_dp (
  input  logic                                   clk,
  input  logic                                   rst,
  input  pcmmix_pkg::ctl_t                       ctl,
  output pcmmix_pkg::stat_t                      stat,
  input  logic [pcmmix_pkg::OP_W-1:0]            command,
  input  logic [pcmmix_pkg::CHAN_W-1:0]          channel,
  input  logic [pcmmix_pkg::GAIN_W-1:0]          volume,
  input  logic [pcmmix_pkg::FIELD_W-1:0]         address,
  input  logic [pcmmix_pkg::FIELD_W-1:0]         length,
  input  logic signed [pcmmix_pkg::SAMPLE_W-1:0] sample_value,
  input  logic [pcmmix_pkg::COUNT_W-1:0]         sample_count,
  output logic                                   res_valid,
  input  logic                                   res_ready,
  output logic signed [pcmmix_pkg::SAMPLE_W-1:0] res_sample,
  output logic                                   res_last,
  output logic                                   res_chan_active,
  output logic                                   res_any_active,
  output logic [pcmmix_pkg::MASK_W-1:0]          res_mask
);

  localparam int CHN   = pcmmix_pkg::CHANNELS;
  localparam int FW    = pcmmix_pkg::FIELD_W;
  localparam int ACC_W = pcmmix_pkg::ACC_W;

  // Captured item
  logic [pcmmix_pkg::OP_W-1:0]            op;
  logic [pcmmix_pkg::CHAN_W-1:0]          chan;
  logic [pcmmix_pkg::GAIN_W-1:0]          vol;
  logic [FW-1:0]                          addr;
  logic [FW-1:0]                          len;
  logic signed [pcmmix_pkg::SAMPLE_W-1:0] sval;
  logic [pcmmix_pkg::CNT_W-1:0]           cnt;

  // Voices
  logic [FW-1:0]                 vbase [CHN];
  logic [FW-1:0]                 vlen  [CHN];
  logic [FW-1:0]                 vpos  [CHN];
  logic [pcmmix_pkg::GAIN_W-1:0] vgain [CHN];
  logic [CHN-1:0]                active;
  logic [CHN-1:0]                mix_mask;

  logic [FW-1:0] avail [CHN];
  logic [FW-1:0] take  [CHN];
  logic [FW-1:0] cnt_w;
  logic          in_range;

  // Pipeline
  logic [pcmmix_pkg::ADDR_W-1:0]          rd_addr;
  logic                                   use_now;
  logic signed [pcmmix_pkg::SAMPLE_W-1:0] rdata;
  logic                                   s1_use;
  logic [pcmmix_pkg::GAIN_W-1:0]          s1_gain;
  logic                                   s2_use;
  logic signed [pcmmix_pkg::PROD_W-1:0]   prod;
  logic signed [pcmmix_pkg::SAMPLE_W-1:0] scaled;
  logic signed [ACC_W-1:0]                acc;
  logic signed [pcmmix_pkg::SAMPLE_W-1:0] clamped;

  logic [pcmmix_pkg::MASK_W+CHN-1:0] active_ext;
  logic [pcmmix_pkg::MASK_W-1:0]     mask8;
  logic                              out_free;
  logic                              store_we;

  // Capture the accepted item, fill size clamped to the chunk limit
  always_ff @(posedge clk) begin
    if (ctl.latch) begin
      op   <= command;
      chan <= channel;
      vol  <= volume;
      addr <= address;
      len  <= length;
      sval <= sample_value;
      cnt  <= (32'(sample_count) > pcmmix_pkg::MAX_CHUNK) ?
              pcmmix_pkg::CNT_W'(pcmmix_pkg::MAX_CHUNK) : pcmmix_pkg::CNT_W'(sample_count);
    end
  end

  assign in_range = (32'(chan) < CHN);
  assign cnt_w    = FW'(cnt);

  // Samples left per voice and samples this fill takes from it
  always_comb begin
    for (int i = 0; i < CHN; i++) begin
      avail[i] = (vlen[i] > vpos[i]) ? FW'(vlen[i] - vpos[i]) : '0;
      take[i]  = (cnt_w < avail[i]) ? cnt_w : avail[i];
    end
  end

  // Active flags: a fill drops every voice it runs dry, settled up front
  always_ff @(posedge clk) begin
    if (rst) begin
      active   <= '0;
      mix_mask <= '0;
    end else begin
      if (ctl.exec && in_range) begin
        for (int i = 0; i < CHN; i++) begin
          if (32'(chan) == 32'(i)) begin
            if (op == pcmmix_pkg::CMD_START) active[i] <= 1'b1;
            if (op == pcmmix_pkg::CMD_STOP)  active[i] <= 1'b0;
          end
        end
      end
      if (ctl.prep) begin
        mix_mask <= active;
        for (int i = 0; i < CHN; i++) begin
          active[i] <= active[i] && (cnt_w < avail[i]);
        end
      end
    end
  end

  // Voice parameters and positions
  always_ff @(posedge clk) begin
    if (ctl.exec && in_range) begin
      for (int i = 0; i < CHN; i++) begin
        if (32'(chan) == 32'(i)) begin
          if (op == pcmmix_pkg::CMD_START) begin
            vbase[i] <= addr;
            vlen[i]  <= len;
            vpos[i]  <= '0;
            vgain[i] <= vol;
          end
          if (op == pcmmix_pkg::CMD_VOLUME) vgain[i] <= vol;
        end
      end
    end
    if (ctl.finish) begin
      for (int i = 0; i < CHN; i++) begin
        if (mix_mask[i]) vpos[i] <= FW'(vpos[i] + take[i]);
      end
    end
  end

  // Issue: address of this channel's sample and whether it still plays
  assign rd_addr = pcmmix_pkg::ADDR_W'(32'(vbase[ctl.chan_idx]) + 32'(vpos[ctl.chan_idx])
                   + 32'(ctl.sample_idx));
  assign use_now = mix_mask[ctl.chan_idx] &&
                   ((32'(vpos[ctl.chan_idx]) + 32'(ctl.sample_idx)) < 32'(vlen[ctl.chan_idx]));
  assign store_we = ctl.exec && (op == pcmmix_pkg::CMD_WRITE);

  pcmmix_ram #(
    .WIDTH (pcmmix_pkg::SAMPLE_W),
    .DEPTH (pcmmix_pkg::STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (store_we),
    .waddr (pcmmix_pkg::ADDR_W'(addr)),
    .wdata (sval),
    .raddr (rd_addr),
    .rdata (rdata)
  );

  // Tag and multiply stages
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_use <= 1'b0;
      s2_use <= 1'b0;
    end else begin
      s1_use <= ctl.issue && use_now;
      s2_use <= s1_use;
    end
  end

  always_ff @(posedge clk) begin
    s1_gain <= vgain[ctl.chan_idx];
    prod    <= rdata * $signed({1'b0, s1_gain});
  end

  // Arithmetic shift floors the scaled product
  assign scaled = prod[pcmmix_pkg::SAMPLE_W+6:7];

  // Accumulate; clear at fill start and after each delivered sample
  always_ff @(posedge clk) begin
    if (ctl.prep || ctl.load_out) begin
      acc <= '0;
    end else if (s2_use) begin
      acc <= ACC_W'(acc + ACC_W'(scaled));
    end
  end

  always_comb begin
    if (acc > pcmmix_pkg::MIX_MAX)      clamped = pcmmix_pkg::SAMPLE_W'(pcmmix_pkg::MIX_MAX);
    else if (acc < pcmmix_pkg::MIX_MIN) clamped = pcmmix_pkg::SAMPLE_W'(pcmmix_pkg::MIX_MIN);
    else                                clamped = pcmmix_pkg::SAMPLE_W'(acc);
  end

  // Status view of the active flags
  assign active_ext = (pcmmix_pkg::MASK_W + CHN)'(active);
  assign mask8      = active_ext[pcmmix_pkg::MASK_W-1:0];

  // Result register
  assign out_free = !res_valid || res_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (ctl.load_out) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load_out) begin
      res_sample      <= ctl.out_fill ? clamped : '0;
      res_last        <= ctl.out_last;
      res_chan_active <= mask8[chan];
      res_any_active  <= |active;
      res_mask        <= mask8;
    end
  end

  assign stat.op       = op;
  assign stat.cnt      = cnt;
  assign stat.out_free = out_free;

endmodule
